/* rtl/core/srm_pkg.sv */
`timescale 1ns / 1ps

package srm_pkg;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [4:0] LEN_PRE   = 5'd6;
  localparam logic [4:0] LEN_RDATA = 5'd21;
  localparam logic [4:0] LEN_BYTE  = 5'd27;

  localparam logic [7:0] ADDR_SPLIT = 8'd128;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_PRE   = 7'b0000010,
    PH_FRAME = 7'b0000100,
    PH_REGB  = 7'b0001000,
    PH_WDATA = 7'b0010000,
    PH_RDATA = 7'b0100000,
    PH_HOLD  = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  reg_address;
    logic [15:0] write_value;
    logic        sda_in;
  } srm_in_t;

  typedef struct packed {
    logic        scl;
    logic        sda;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_value;
    logic        rejected;
  } srm_out_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } srm_pins_t;

  typedef struct packed {
    phase_e      phase;
    logic [4:0]  step_index;
    logic [1:0]  byte_access_index;
    logic [15:0] prescale_count;
    logic        is_write;
    logic [7:0]  latched_address;
    logic [15:0] latched_value;
    logic [7:0]  shift_byte;
    logic [15:0] read_accum;
    srm_pins_t   pins;
  } srm_state_t;

  // one pin step of a byte segment
  function automatic srm_pins_t byte_step(srm_pins_t pins, logic [4:0] k,
                                          logic [7:0] data, logic trailer);
    srm_pins_t  p;
    logic [4:0] km1;
    logic [2:0] grp;
    logic [4:0] sub;
    logic [2:0] bit_idx;
    p   = pins;
    km1 = k - 5'd1;
    grp = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (km1 >= 5'(3 * i)) grp = 3'(i);
    end
    sub     = km1 - 5'({grp, 1'b0}) - 5'(grp);
    bit_idx = 3'd7 - grp;
    if (k == 5'd0) begin
      p.scl = 1'b0;
    end else if (k <= 5'd24) begin
      if (sub == 5'd0) p.sda = data[bit_idx];
      else p.scl = (sub == 5'd1);
    end else if (k == 5'd25) begin
      p.sda = trailer;
    end else begin
      p.scl = 1'b1;
    end
    return p;
  endfunction

endpackage

/* rtl/core/serial_register_access_master.sv */
`timescale 1ns / 1ps
// channel   direction  handshake              word
// cfg       in         cfg_we_i               cfg_wdata_i (ticks_per_step)
// in        in         in_valid_i/in_stall_o   in_word_i (srm_in_t)
// out       out        out_valid_o/out_stall_i out_word_o (srm_out_t)
//
// One word per cycle while in_stall_o is low: each accepted word updates the
// sequencer state and the output register at the same clock edge.
// Reset puts the pins high and driven, the sequencer idle, ticks_per_step 1.
// in_stall_o is high only while a result waits in the output register and
// out_stall_i is high.

module serial_register_access_master (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  srm_pkg::srm_in_t in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output srm_pkg::srm_out_t out_word_o
);
  import srm_pkg::*;

  logic [15:0] tps_q;
  srm_state_t  st_q;
  srm_state_t  st_d;
  srm_out_t    res;
  logic        accept;
  logic        blocked;

  assign in_stall_o = blocked;
  assign accept     = in_valid_i & ~blocked;

  srm_step u_step (
    .st_i             (st_q),
    .word_i           (in_word_i),
    .ticks_per_step_i (tps_q),
    .st_o             (st_d),
    .word_o           (res)
  );

  srm_out_stage u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept),
    .word_i         (res),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .out_word_o     (out_word_o),
    .full_stalled_o (blocked)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= 16'd1;
    end else if (cfg_we_i) begin
      tps_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase             <= PH_IDLE;
      st_q.step_index        <= 5'd0;
      st_q.byte_access_index <= 2'd0;
      st_q.prescale_count    <= 16'd0;
      st_q.is_write          <= 1'b0;
      st_q.latched_address   <= 8'd0;
      st_q.latched_value     <= 16'd0;
      st_q.shift_byte        <= 8'd0;
      st_q.read_accum        <= 16'd0;
      st_q.pins              <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
    end else if (accept) begin
      st_q <= st_d;
    end
  end

endmodule

/* rtl/core/srm_step.sv */
`timescale 1ns / 1ps

module srm_step (
  input  srm_pkg::srm_state_t st_i,
  input  srm_pkg::srm_in_t    word_i,
  input  logic [15:0]         ticks_per_step_i,
  output srm_pkg::srm_state_t st_o,
  output srm_pkg::srm_out_t   word_o
);
  import srm_pkg::*;

  always_comb begin
    srm_state_t  s;
    logic [15:0] tps;
    logic [15:0] pc;
    logic        done;
    logic        rejected;
    logic        writes;
    logic        high;
    logic [7:0]  reg_byte;
    logic [7:0]  data_byte;
    logic [4:0]  k;
    logic [4:0]  k1;
    logic [4:0]  len;

    s        = st_i;
    done     = 1'b0;
    rejected = 1'b0;
    tps      = (ticks_per_step_i == 16'd0) ? 16'd1 : ticks_per_step_i;
    writes   = st_i.is_write | (st_i.byte_access_index < 2'd2);
    high     = st_i.latched_address > ADDR_SPLIT;
    k        = st_i.step_index;
    k1       = k + 5'd1;

    unique case (st_i.byte_access_index)
      2'd0: reg_byte = high ? 8'd3 : 8'd4;
      2'd1: reg_byte = high ? 8'd4 : 8'd3;
      2'd2: reg_byte = 8'd2;
      default: reg_byte = 8'd1;
    endcase
    unique case (st_i.byte_access_index)
      2'd0: data_byte = 8'd0;
      2'd1: data_byte = st_i.latched_address;
      2'd2: data_byte = st_i.latched_value[7:0];
      default: data_byte = st_i.latched_value[15:8];
    endcase

    unique case (st_i.phase)
      PH_PRE:   len = LEN_PRE;
      PH_RDATA: len = LEN_RDATA;
      default:  len = LEN_BYTE;
    endcase

    if (word_i.action == ACT_READ || word_i.action == ACT_WRITE) begin
      if (st_i.phase != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        s.is_write          = word_i.action[0];
        s.latched_address   = word_i.reg_address;
        s.latched_value     = word_i.write_value;
        s.shift_byte        = 8'd0;
        s.byte_access_index = 2'd0;
        s.step_index        = 5'd0;
        s.prescale_count    = 16'd0;
        s.phase             = PH_PRE;
      end
    end else if (word_i.action == ACT_TICK && st_i.phase != PH_IDLE) begin
      if (st_i.prescale_count == 16'd0 && st_i.phase != PH_HOLD) begin
        unique case (st_i.phase)
          PH_PRE: begin
            if (k == 5'd1 || k == 5'd3) s.pins.sda = 1'b1;
            else s.pins.scl = (k == 5'd0 || k == 5'd4);
          end
          PH_FRAME: s.pins = byte_step(st_i.pins, k, 8'd1, writes);
          PH_REGB:  s.pins = byte_step(st_i.pins, k, reg_byte, 1'b0);
          PH_WDATA: s.pins = byte_step(st_i.pins, k, data_byte, 1'b1);
          default: begin
            if (k == 5'd0) begin
              s.pins.drv = 1'b0;
            end else if (k <= 5'd16) begin
              if (!k[0]) begin
                s.pins.scl = 1'b1;
              end else begin
                s.shift_byte = {st_i.shift_byte[6:0], word_i.sda_in};
                s.pins.scl   = 1'b0;
              end
            end else if (k == 5'd17) begin
              s.pins.drv = 1'b1;
            end else if (k == 5'd18) begin
              s.pins.scl = 1'b0;
            end else if (k == 5'd19) begin
              s.pins.sda = 1'b1;
            end else begin
              s.pins.scl = 1'b1;
            end
          end
        endcase

        if (k1 < len) begin
          s.step_index = k1;
        end else begin
          s.step_index = 5'd0;
          unique case (st_i.phase)
            PH_PRE:   s.phase = PH_FRAME;
            PH_FRAME: s.phase = PH_REGB;
            PH_REGB:  s.phase = writes ? PH_WDATA : PH_RDATA;
            default: begin
              if (st_i.phase == PH_RDATA && st_i.byte_access_index == 2'd2) begin
                s.latched_value = {8'd0, s.shift_byte};
              end
              if (st_i.byte_access_index == 2'd3) begin
                s.phase = PH_HOLD;
              end else begin
                s.byte_access_index = st_i.byte_access_index + 2'd1;
                s.phase             = PH_PRE;
              end
            end
          endcase
        end
      end

      pc = st_i.prescale_count + 16'd1;
      if (pc >= tps) begin
        s.prescale_count = 16'd0;
        if (s.phase == PH_HOLD) begin
          s.phase = PH_IDLE;
          done    = 1'b1;
          if (!s.is_write) s.read_accum = {s.shift_byte, s.latched_value[7:0]};
        end
      end else begin
        s.prescale_count = pc;
      end
    end

    st_o                = s;
    word_o.scl          = s.pins.scl;
    word_o.sda          = s.pins.sda;
    word_o.sda_drive    = s.pins.drv;
    word_o.busy_res     = (s.phase != PH_IDLE);
    word_o.done_res     = done;
    word_o.read_value   = s.read_accum;
    word_o.rejected     = rejected;
  end

endmodule

/* rtl/core/srm_out_stage.sv */
`timescale 1ns / 1ps

module srm_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  srm_pkg::srm_out_t word_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output srm_pkg::srm_out_t out_word_o,
  output logic              full_stalled_o
);
  import srm_pkg::*;

  logic     valid_q;
  logic     valid_d;
  srm_out_t word_q;

  assign valid_d        = load_i | (valid_q & out_stall_i);
  assign full_stalled_o = valid_q & out_stall_i;
  assign out_valid_o    = valid_q;
  assign out_word_o     = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

endmodule
